// ===== hdl/dwtg_pkg.sv =====
// Package for the depth window target gate: widths, register codes and the
// structs passed between the front end, the verdict queue and the back end.
// Depends on nothing; every other file imports it.
package dwtg_pkg;

  // Field widths.
  localparam int COORD_BITS    = 12;
  localparam int COUNT_BITS    = 20;
  localparam int DEPTH_BITS    = 16;
  localparam int INV_BITS      = 24;
  localparam int INV_LO_BITS   = 12;
  localparam int INV_HI_BITS   = INV_BITS - INV_LO_BITS;
  localparam int FRAC_BITS     = 24;
  localparam int TGT_BITS      = 18;
  localparam int TZ_BITS       = 17;
  localparam int ERR_BITS      = 34;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 34;

  // Arithmetic widths of the projection and distance datapath.
  localparam int PM_BITS   = COORD_BITS + DEPTH_BITS;     // |du| * d
  localparam int PL_BITS   = PM_BITS + INV_LO_BITS;       // partial product, low half
  localparam int PH_BITS   = PM_BITS + INV_HI_BITS;       // partial product, high half
  localparam int PROD_BITS = PM_BITS + INV_BITS + 1;      // full product plus rounding carry
  localparam int R_BITS    = PROD_BITS - FRAC_BITS;       // rounded magnitude in mm
  localparam int DX_BITS   = R_BITS + 2;                  // signed difference to target
  localparam int AX_BITS   = R_BITS + 1;                  // magnitude of that difference
  localparam int SQ_BITS   = 2 * AX_BITS;
  localparam int DZ_BITS   = TZ_BITS + 1;
  localparam int AZ_BITS   = TZ_BITS;
  localparam int SQZ_BITS  = 2 * AZ_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;

  // Pipeline and queue sizes.
  localparam int PIPE_STAGES = 7;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_INV_FOCAL_X  = 3'd2,
    REG_INV_FOCAL_Y  = 3'd3,
    REG_TARGET_X     = 3'd4,
    REG_TARGET_Y     = 3'd5,
    REG_TARGET_Z     = 3'd6,
    REG_MAX_ERROR_SQ = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [INV_BITS-1:0]   inv_focal_x;
    logic [INV_BITS-1:0]   inv_focal_y;
    logic [TGT_BITS-1:0]   target_x;
    logic [TGT_BITS-1:0]   target_y;
    logic [TZ_BITS-1:0]    target_z;
    logic [ERR_BITS-1:0]   max_error_sq;
  } cfg_t;

  // One input pixel item.
  typedef struct packed {
    logic [COORD_BITS-1:0] column;
    logic [COORD_BITS-1:0] row;
    logic [DEPTH_BITS-1:0] depth;
    logic                  last;
  } pix_t;

  // A classified pixel waiting for the back end.
  typedef struct packed {
    logic hit;
    pix_t pix;
  } verdict_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== hdl/dwtg_front.sv =====
// Front end: back-projects each pixel and tests it against the target sphere.
// Seven-stage pipeline that halts as a whole when the verdict queue is full and
// its last stage holds an item. Depends on dwtg_pkg.
module dwtg_front import dwtg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_stall,
  input  pix_t     in_pix,
  input  qstat_t   qstat,
  output logic     push,
  output verdict_t push_item
);

  logic                   adv;
  logic [PIPE_STAGES-1:0] vld;
  pix_t                   pix [PIPE_STAGES];

  // Lane 0 is x (columns), lane 1 is y (rows).
  logic [COORD_BITS-1:0] l_coord  [2];
  logic [COORD_BITS-1:0] l_center [2];
  logic [INV_BITS-1:0]   l_inv    [2];
  logic [TGT_BITS-1:0]   l_tgt    [2];

  // Stage registers.
  logic                  neg1 [2];
  logic [COORD_BITS-1:0] mag1 [2];
  logic [AZ_BITS-1:0]    az1;
  logic                  neg2 [2];
  logic [PM_BITS-1:0]    pm2  [2];
  logic [SQZ_BITS-1:0]   sqz2;
  logic                  neg3 [2];
  logic [PL_BITS-1:0]    pl3  [2];
  logic [PH_BITS-1:0]    ph3  [2];
  logic [SQZ_BITS-1:0]   sqz3;
  logic                  neg4 [2];
  logic [R_BITS-1:0]     r4   [2];
  logic [SQZ_BITS-1:0]   sqz4;
  logic [AX_BITS-1:0]    ax5  [2];
  logic [SQZ_BITS-1:0]   sqz5;
  logic [SQ_BITS-1:0]    sq6  [2];
  logic [SQZ_BITS-1:0]   sqz6;
  logic                  hit7;

  // Combinational values feeding the stage registers.
  logic signed [DZ_BITS-1:0] dz_c;
  logic [PROD_BITS-1:0]      prod_c [2];
  logic signed [DX_BITS-1:0] dx_c   [2];
  logic [SUM_BITS-1:0]       sum_c;

  // The pipeline moves unless its last stage holds an item the queue cannot take.
  assign adv      = !vld[PIPE_STAGES-1] || !qstat.full;
  assign in_stall = !adv;
  assign push     = vld[PIPE_STAGES-1] && !qstat.full;
  assign push_item.hit = hit7;
  assign push_item.pix = pix[PIPE_STAGES-1];

  // Per-lane operand selection.
  always_comb begin
    l_coord[0]  = in_pix.column;
    l_coord[1]  = in_pix.row;
    l_center[0] = cfg.center_x;
    l_center[1] = cfg.center_y;
    l_inv[0]    = cfg.inv_focal_x;
    l_inv[1]    = cfg.inv_focal_y;
    l_tgt[0]    = cfg.target_x;
    l_tgt[1]    = cfg.target_y;
  end

  // Depth difference, combined products with rounding, target differences, sum.
  always_comb begin
    dz_c = $signed({2'b00, in_pix.depth}) - $signed({1'b0, cfg.target_z});
    for (int i = 0; i < 2; i++) begin
      prod_c[i] = PROD_BITS'(pl3[i]) + (PROD_BITS'(ph3[i]) << INV_LO_BITS)
                + (PROD_BITS'(1) << (FRAC_BITS - 1));
      if (neg4[i]) begin
        dx_c[i] = -$signed(DX_BITS'(r4[i])) - DX_BITS'($signed(l_tgt[i]));
      end else begin
        dx_c[i] = $signed(DX_BITS'(r4[i])) - DX_BITS'($signed(l_tgt[i]));
      end
    end
    sum_c = SUM_BITS'(sq6[0]) + SUM_BITS'(sq6[1]) + SUM_BITS'(sqz6);
  end

  // Valid bits of the stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_STAGES-2:0], in_valid};
    end
  end

  // Datapath registers, advanced together.
  always_ff @(posedge clk) begin
    if (adv) begin
      pix[0] <= in_pix;
      for (int s = 1; s < PIPE_STAGES; s++) begin
        pix[s] <= pix[s-1];
      end
      for (int i = 0; i < 2; i++) begin
        // Stage 1: offset from the principal point, as sign and magnitude.
        neg1[i] <= l_coord[i] < l_center[i];
        mag1[i] <= (l_coord[i] < l_center[i]) ? (l_center[i] - l_coord[i])
                                              : (l_coord[i] - l_center[i]);
        // Stage 2: magnitude times depth.
        neg2[i] <= neg1[i];
        pm2[i]  <= PM_BITS'(mag1[i]) * PM_BITS'(pix[0].depth);
        // Stage 3: two partial products with the focal reciprocal.
        neg3[i] <= neg2[i];
        pl3[i]  <= PL_BITS'(pm2[i]) * PL_BITS'(l_inv[i][INV_LO_BITS-1:0]);
        ph3[i]  <= PH_BITS'(pm2[i]) * PH_BITS'(l_inv[i][INV_BITS-1:INV_LO_BITS]);
        // Stage 4: round to whole millimetres, ties away from zero.
        neg4[i] <= neg3[i];
        r4[i]   <= prod_c[i][PROD_BITS-1:FRAC_BITS];
        // Stage 5: distance to the target along this axis.
        ax5[i]  <= dx_c[i][DX_BITS-1] ? AX_BITS'(-dx_c[i]) : AX_BITS'(dx_c[i]);
        // Stage 6: square.
        sq6[i]  <= SQ_BITS'(ax5[i]) * SQ_BITS'(ax5[i]);
      end
      // The depth axis needs no projection; its square is carried along.
      az1  <= dz_c[DZ_BITS-1] ? AZ_BITS'(-dz_c) : AZ_BITS'(dz_c);
      sqz2 <= SQZ_BITS'(az1) * SQZ_BITS'(az1);
      sqz3 <= sqz2;
      sqz4 <= sqz3;
      sqz5 <= sqz4;
      sqz6 <= sqz5;
      // Stage 7: strict comparison with the limit.
      hit7 <= sum_c < SUM_BITS'(cfg.max_error_sq);
    end
  end

endmodule

// ===== hdl/dwtg_queue.sv =====
// Verdict queue: a short register FIFO between the front and back ends.
// Depends on dwtg_pkg.
module dwtg_queue import dwtg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  verdict_t push_item,
  input  logic     pop,
  output verdict_t pop_item,
  output qstat_t   qstat
);

  verdict_t               mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QPTR_BITS:0]     count;

  assign qstat.full  = count == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign pop_item    = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== hdl/dwtg_back.sv =====
// Back end: keeps the hit count and bounding box of the window and holds
// the output register. Depends on dwtg_pkg.
module dwtg_back import dwtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  qstat_t                qstat,
  input  verdict_t              pop_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_hit,
  output logic [DEPTH_BITS-1:0] depth_out,
  output logic                  final_flag,
  output logic [COUNT_BITS-1:0] hit_total,
  output logic [COORD_BITS-1:0] box_left,
  output logic [COORD_BITS-1:0] box_top,
  output logic [COORD_BITS-1:0] box_right,
  output logic [COORD_BITS-1:0] box_bottom
);

  logic [COUNT_BITS-1:0] hit_counter;
  logic [COORD_BITS-1:0] min_column;
  logic [COORD_BITS-1:0] min_row;
  logic [COORD_BITS-1:0] max_column;
  logic [COORD_BITS-1:0] max_row;

  logic [COUNT_BITS-1:0] hit_counter_next;
  logic [COORD_BITS-1:0] min_column_next;
  logic [COORD_BITS-1:0] min_row_next;
  logic [COORD_BITS-1:0] max_column_next;
  logic [COORD_BITS-1:0] max_row_next;

  // Take an item whenever the output register is free or being emptied.
  assign pop = !qstat.empty && (!out_valid || !out_stall);

  // Window statistics including the item at the head of the queue.
  always_comb begin
    hit_counter_next = hit_counter;
    min_column_next  = min_column;
    min_row_next     = min_row;
    max_column_next  = max_column;
    max_row_next     = max_row;
    if (pop_item.hit) begin
      if (hit_counter != COUNT_MAX) begin
        hit_counter_next = hit_counter + 1'b1;
      end
      if (pop_item.pix.column < min_column) begin
        min_column_next = pop_item.pix.column;
      end
      if (pop_item.pix.row < min_row) begin
        min_row_next = pop_item.pix.row;
      end
      if (pop_item.pix.column > max_column) begin
        max_column_next = pop_item.pix.column;
      end
      if (pop_item.pix.row > max_row) begin
        max_row_next = pop_item.pix.row;
      end
    end
  end

  // Statistics and output valid; the window's last pixel clears the statistics.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      hit_counter <= '0;
      min_column  <= COORD_MAX;
      min_row     <= COORD_MAX;
      max_column  <= '0;
      max_row     <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      if (pop_item.pix.last) begin
        hit_counter <= '0;
        min_column  <= COORD_MAX;
        min_row     <= COORD_MAX;
        max_column  <= '0;
        max_row     <= '0;
      end else begin
        hit_counter <= hit_counter_next;
        min_column  <= min_column_next;
        min_row     <= min_row_next;
        max_column  <= max_column_next;
        max_row     <= max_row_next;
      end
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      is_hit     <= pop_item.hit;
      depth_out  <= pop_item.hit ? '0 : pop_item.pix.depth;
      final_flag <= pop_item.pix.last;
      hit_total  <= hit_counter_next;
      box_left   <= min_column_next;
      box_top    <= min_row_next;
      box_right  <= max_column_next;
      box_bottom <= max_row_next;
    end
  end

endmodule

// ===== hdl/depth_window_target_gate_top.sv =====
// Depth window target gate, top level: configuration registers, front end,
// verdict queue and back end. Depends on dwtg_pkg, dwtg_front, dwtg_queue, dwtg_back.
//
// Use: stream the pixels of a search window in raster order on the input
// channel (pixel_column, pixel_row, raw_depth, window_end). An item moves on
// an edge where its valid is high and its stall is low. Each pixel gives one
// result item: is_hit, depth_out (zero on a hit), final_flag, and the running
// hit_total and hit bounding box of the window. After the result of the pixel
// marked window_end the count and box return to empty.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data; the user
// must write them only while the block is idle; the block does not enforce it.
// cfg_ready is always high. A result passes the seven front-end stages, one
// queue slot and the output register.
// Throughput: one pixel per cycle unless stalled; the front end is fully pipelined.
// Stall: the back end holds its output register; the four-entry queue fills,
// then the front-end pipeline halts as a whole and in_stall rises.
// Reset (rst, synchronous) clears the configuration registers, the window
// statistics and every item in flight; the datapath and output payload are not reset.
module depth_window_target_gate_top import dwtg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [COORD_BITS-1:0]    pixel_column,
  input  logic [COORD_BITS-1:0]    pixel_row,
  input  logic [DEPTH_BITS-1:0]    raw_depth,
  input  logic                     window_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     is_hit,
  output logic [DEPTH_BITS-1:0]    depth_out,
  output logic                     final_flag,
  output logic [COUNT_BITS-1:0]    hit_total,
  output logic [COORD_BITS-1:0]    box_left,
  output logic [COORD_BITS-1:0]    box_top,
  output logic [COORD_BITS-1:0]    box_right,
  output logic [COORD_BITS-1:0]    box_bottom
);

  cfg_t     cfg;
  pix_t     in_pix;
  qstat_t   qstat;
  logic     push;
  logic     pop;
  verdict_t push_item;
  verdict_t pop_item;

  assign cfg_ready = 1'b1;

  assign in_pix.column = pixel_column;
  assign in_pix.row    = pixel_row;
  assign in_pix.depth  = raw_depth;
  assign in_pix.last   = window_end;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:     cfg.center_x     <= cfg_data[COORD_BITS-1:0];
        REG_CENTER_Y:     cfg.center_y     <= cfg_data[COORD_BITS-1:0];
        REG_INV_FOCAL_X:  cfg.inv_focal_x  <= cfg_data[INV_BITS-1:0];
        REG_INV_FOCAL_Y:  cfg.inv_focal_y  <= cfg_data[INV_BITS-1:0];
        REG_TARGET_X:     cfg.target_x     <= cfg_data[TGT_BITS-1:0];
        REG_TARGET_Y:     cfg.target_y     <= cfg_data[TGT_BITS-1:0];
        REG_TARGET_Z:     cfg.target_z     <= cfg_data[TZ_BITS-1:0];
        REG_MAX_ERROR_SQ: cfg.max_error_sq <= cfg_data[ERR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Classification pipeline.
  dwtg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pix    (in_pix),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item)
  );

  // Queue between the two halves.
  dwtg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .qstat     (qstat)
  );

  // Window statistics and output register.
  dwtg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .qstat      (qstat),
    .pop_item   (pop_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_hit     (is_hit),
    .depth_out  (depth_out),
    .final_flag (final_flag),
    .hit_total  (hit_total),
    .box_left   (box_left),
    .box_top    (box_top),
    .box_right  (box_right),
    .box_bottom (box_bottom)
  );

`ifndef SYNTH
  // A window with hits has a well-formed box.
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit_total != '0) |-> (box_left <= box_right && box_top <= box_bottom))
    else $error("hit box is inverted");

  // A hit zeroes the depth and is counted.
  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_hit) |-> (depth_out == '0 && hit_total != '0))
    else $error("hit not zeroed or not counted");

  // A window without hits reports the empty box.
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit_total == '0) |->
      (box_left == COORD_MAX && box_top == COORD_MAX && box_right == '0 && box_bottom == '0))
    else $error("empty window reports a box");

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full))
    else $error("verdict queue overflow");
`endif

endmodule
